/* src/tpc_pkg.sv */
// ============================================================================
// Timer pool controller package
// Request and phase codes, and the items passed between the pipeline stages.
// ============================================================================
`default_nettype none

package tpc_pkg;

  localparam int TICK_W     = 32;
  localparam int SLOT_IDX_W = 3;
  localparam int ADDR_MAX   = 8;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_CREATE  = 3'd1,
    REQ_START   = 3'd2,
    REQ_CHECK   = 3'd3,
    REQ_STOP    = 3'd4,
    REQ_DESTROY = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_RUN   = 2'd2,
    PH_FIRED = 2'd3
  } phase_t;

  typedef struct packed {
    req_t                    req_type;
    logic [SLOT_IDX_W-1:0]   slot_index;
    logic [TICK_W-1:0]       delay_ticks;
    logic [TICK_W-1:0]       period_ticks;
    logic                    repeat_enable;
    logic [TICK_W-1:0]       fire_offset;
  } req_item_t;

  typedef struct packed {
    logic                    op_failed;
    logic [SLOT_IDX_W-1:0]   granted_slot;
    phase_t                  timer_phase;
  } rsp_item_t;

endpackage

`default_nettype wire

/* src/timer_pool_controller_top.sv */
// ============================================================================
// Timer pool controller
// Pool of timer slots on a shared wrapping 32-bit tick counter.
// ============================================================================
// Takes one request item per clock unless a result is stalled, and returns
// exactly one result item for each, in order. A request is held in the input
// register and passes through the slot decode into the result register once
// that register has space. A result that is not taken holds both registers.
// State lives in flip-flops, so there is no clearing pass after reset. Only
// slots 0 to 7 are addressable; NUM_SLOTS sets how many of those exist.
`default_nettype none

module timer_pool_controller_top #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     in_req_type,
  input  wire logic [tpc_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  wire logic [tpc_pkg::TICK_W-1:0]     in_delay_ticks,
  input  wire logic [tpc_pkg::TICK_W-1:0]     in_period_ticks,
  input  wire logic                           in_repeat_enable,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_op_failed,
  output logic [tpc_pkg::SLOT_IDX_W-1:0]      out_granted_slot,
  output logic [1:0]                          out_timer_phase
);

  localparam int ADDR_SLOTS = (NUM_SLOTS < tpc_pkg::ADDR_MAX) ? NUM_SLOTS : tpc_pkg::ADDR_MAX;

  tpc_pkg::req_item_t req;
  tpc_pkg::rsp_item_t rsp;
  logic               take;
  logic               space;

  tpc_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_slot_index    (in_slot_index),
    .in_delay_ticks   (in_delay_ticks),
    .in_period_ticks  (in_period_ticks),
    .in_repeat_enable (in_repeat_enable),
    .space            (space),
    .take             (take),
    .req              (req)
  );

  tpc_slot_bank #(
    .ADDR_SLOTS (ADDR_SLOTS)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .req   (req),
    .rsp   (rsp)
  );

  tpc_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .rsp              (rsp),
    .space            (space),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_op_failed    (out_op_failed),
    .out_granted_slot (out_granted_slot),
    .out_timer_phase  (out_timer_phase)
  );

endmodule

`default_nettype wire

/* src/tpc_in_stage.sv */
// ============================================================================
// Timer pool controller input register
// Holds one accepted request item and its delay plus period offset.
// ============================================================================
`default_nettype none

module tpc_in_stage (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     in_req_type,
  input  wire logic [tpc_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  wire logic [tpc_pkg::TICK_W-1:0]     in_delay_ticks,
  input  wire logic [tpc_pkg::TICK_W-1:0]     in_period_ticks,
  input  wire logic                           in_repeat_enable,
  input  wire logic                           space,
  output logic                                take,
  output tpc_pkg::req_item_t                  req
);

  tpc_pkg::req_item_t req_r;
  logic               valid_r;

  assign take     = valid_r && space;
  assign in_ready = !valid_r || space;
  assign req      = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.req_type      <= tpc_pkg::req_t'(in_req_type);
      req_r.slot_index    <= in_slot_index;
      req_r.delay_ticks   <= in_delay_ticks;
      req_r.period_ticks  <= in_period_ticks;
      req_r.repeat_enable <= in_repeat_enable;
      req_r.fire_offset   <= in_delay_ticks + in_period_ticks;
    end
  end

endmodule

`default_nettype wire

/* src/tpc_slot_bank.sv */
// ============================================================================
// Timer pool controller slot bank
// Tick counter and slot state; decodes one request and updates the pool.
// ============================================================================
`default_nettype none

module tpc_slot_bank #(
  parameter int ADDR_SLOTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire tpc_pkg::req_item_t req,
  output tpc_pkg::rsp_item_t      rsp
);

  logic [tpc_pkg::TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic [ADDR_SLOTS-1:0]      alloc_r, alloc_nxt;
  logic [ADDR_SLOTS-1:0]      run_r, run_nxt;
  logic [ADDR_SLOTS-1:0]      rep_r, rep_nxt;

  logic [tpc_pkg::TICK_W-1:0] end_delay_r [ADDR_SLOTS];
  logic [tpc_pkg::TICK_W-1:0] end_fire_r  [ADDR_SLOTS];
  logic [tpc_pkg::TICK_W-1:0] period_r    [ADDR_SLOTS];

  logic [ADDR_SLOTS-1:0]      hit;
  logic                       in_pool;
  logic                       sel_alloc, sel_run;
  logic [tpc_pkg::TICK_W-1:0] sel_end_delay, sel_end_fire, sel_period;
  logic                       found;
  logic [tpc_pkg::SLOT_IDX_W-1:0] free_idx;
  logic [ADDR_SLOTS-1:0]      free_hit;
  logic [ADDR_SLOTS-1:0]      wr_en;
  logic [tpc_pkg::TICK_W-1:0] wr_end_delay, wr_end_fire, wr_period;

  always_comb begin
    hit           = '0;
    free_hit      = '0;
    found         = 1'b0;
    free_idx      = '0;
    sel_end_delay = '0;
    sel_end_fire  = '0;
    sel_period    = '0;
    for (int s = 0; s < ADDR_SLOTS; s++) begin
      hit[s] = (req.slot_index == tpc_pkg::SLOT_IDX_W'(s));
      if (hit[s]) begin
        sel_end_delay = end_delay_r[s];
        sel_end_fire  = end_fire_r[s];
        sel_period    = period_r[s];
      end
      if (!alloc_r[s] && !found) begin
        found       = 1'b1;
        free_idx    = tpc_pkg::SLOT_IDX_W'(s);
        free_hit[s] = 1'b1;
      end
    end
    in_pool   = |hit;
    sel_alloc = |(hit & alloc_r);
    sel_run   = |(hit & run_r);
  end

  always_comb begin
    tick_count_nxt = tick_count_r;
    alloc_nxt      = alloc_r;
    run_nxt        = run_r;
    rep_nxt        = rep_r;
    wr_en          = '0;
    wr_end_delay   = tick_count_r;
    wr_end_fire    = tick_count_r + sel_period;
    wr_period      = sel_period;
    rsp            = '0;
    unique case (req.req_type)
      tpc_pkg::REQ_TICK: begin
        tick_count_nxt = tick_count_r + tpc_pkg::TICK_W'(1);
      end
      tpc_pkg::REQ_CREATE: begin
        rsp.op_failed = !found;
        if (found) begin
          rsp.granted_slot = free_idx;
          alloc_nxt        = alloc_r | free_hit;
          run_nxt          = run_r & ~free_hit;
          rep_nxt          = rep_r & ~free_hit;
        end
      end
      tpc_pkg::REQ_START: begin
        if (!in_pool || !sel_alloc || sel_run) begin
          rsp.op_failed = 1'b1;
        end else begin
          wr_en        = hit;
          wr_end_delay = tick_count_r + req.delay_ticks;
          wr_end_fire  = tick_count_r + req.fire_offset;
          wr_period    = req.period_ticks;
          run_nxt      = run_r | hit;
          rep_nxt      = req.repeat_enable ? (rep_r | hit) : (rep_r & ~hit);
        end
      end
      tpc_pkg::REQ_CHECK: begin
        if (in_pool && sel_alloc && sel_run) begin
          if (tick_count_r < sel_end_delay) begin
            rsp.timer_phase = tpc_pkg::PH_DELAY;
          end else if (tick_count_r < sel_end_fire) begin
            rsp.timer_phase = tpc_pkg::PH_RUN;
          end else begin
            rsp.timer_phase = tpc_pkg::PH_FIRED;
            if (|(hit & rep_r)) begin
              wr_en = hit;
            end else begin
              alloc_nxt = alloc_r & ~hit;
            end
          end
        end
      end
      tpc_pkg::REQ_STOP: begin
        run_nxt = run_r & ~hit;
      end
      tpc_pkg::REQ_DESTROY: begin
        alloc_nxt = alloc_r & ~hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      alloc_r      <= '0;
      run_r        <= '0;
      rep_r        <= '0;
    end else if (take) begin
      tick_count_r <= tick_count_nxt;
      alloc_r      <= alloc_nxt;
      run_r        <= run_nxt;
      rep_r        <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ADDR_SLOTS; s++) begin
      if (take && wr_en[s]) begin
        end_delay_r[s] <= wr_end_delay;
        end_fire_r[s]  <= wr_end_fire;
        period_r[s]    <= wr_period;
      end
    end
  end

endmodule

`default_nettype wire

/* src/tpc_out_stage.sv */
// ============================================================================
// Timer pool controller result register
// Holds one result item until the consumer takes it.
// ============================================================================
`default_nettype none

module tpc_out_stage (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           take,
  input  wire tpc_pkg::rsp_item_t             rsp,
  output logic                                space,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_op_failed,
  output logic [tpc_pkg::SLOT_IDX_W-1:0]      out_granted_slot,
  output logic [1:0]                          out_timer_phase
);

  tpc_pkg::rsp_item_t rsp_r;
  logic               valid_r;

  assign space            = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_op_failed    = rsp_r.op_failed;
  assign out_granted_slot = rsp_r.granted_slot;
  assign out_timer_phase  = rsp_r.timer_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_r <= rsp;
    end
  end

endmodule

`default_nettype wire

/* src/tpc_checker.sv */
// ============================================================================
// Timer pool controller checker
// Port-level properties of the result channel, bound to the top level.
// ============================================================================
`default_nettype none

module tpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_op_failed,
  input wire logic [2:0] out_granted_slot,
  input wire logic [1:0] out_timer_phase
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_op_failed)
      && $stable(out_granted_slot) && $stable(out_timer_phase))
    else $error("result item changed while stalled");

  a_fail_no_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_failed |-> out_timer_phase == 2'd0 && out_granted_slot == 3'd0)
    else $error("failed item carries a phase or a slot");

  a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted_slot != 3'd0 |-> out_timer_phase == 2'd0)
    else $error("granted slot alongside a phase");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind timer_pool_controller_top tpc_checker u_tpc_checker (.*);

`default_nettype wire
